### rtl/core/retransmit_descriptor_table_defines.svh
// Assertion macros for the retransmit descriptor table checker
`ifndef RETRANSMIT_DESCRIPTOR_TABLE_DEFINES_SVH
`define RETRANSMIT_DESCRIPTOR_TABLE_DEFINES_SVH

// Same-cycle implication, off while reset is high
`define RDT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rdt_checker: same-cycle check failed");

// Next-cycle implication, off while reset is high
`define RDT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rdt_checker: next-cycle check failed");

// Next-cycle implication that also watches reset itself
`define RDT_ASSERT_NEXT_RAW(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("rdt_checker: reset check failed");

`endif

### rtl/core/rdt_pkg.sv
// Shared types and constants of the retransmit descriptor table
`timescale 1ns / 1ps
`default_nettype none

package rdt_pkg;

   // Field widths of one item
   localparam int FRAME_W  = 31;
   localparam int PACKET_W = 16;
   localparam int LENGTH_W = 12;
   localparam int STAMP_W  = 32;
   localparam int SLOT_W   = 6;

   localparam int REQ_FIELDS_W = FRAME_W + PACKET_W + LENGTH_W + STAMP_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = SLOT_W + LENGTH_W + STAMP_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_USER_W   = 2;

   // Largest payload a descriptor records
   localparam logic [LENGTH_W-1:0] MAX_PACKET_BYTES = 12'd2048;

   // Command carried in req_tuser
   localparam logic CMD_STORE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef enum logic [RSP_USER_W-1:0] {
      STATUS_STORED = 2'd0,
      STATUS_HIT    = 2'd1,
      STATUS_MISS   = 2'd2
   } status_type;

   // Input data word, first field in the lowest bits
   typedef struct packed {
      logic [REQ_DATA_W-REQ_FIELDS_W-1:0] pad;
      logic [STAMP_W-1:0]                 now;
      logic [LENGTH_W-1:0]                length;
      logic [PACKET_W-1:0]                packet;
      logic [FRAME_W-1:0]                 frame;
   } req_data_type;

   // Result data word, first field in the lowest bits
   typedef struct packed {
      logic [RSP_DATA_W-RSP_FIELDS_W-1:0] pad;
      logic [STAMP_W-1:0]                 elapsed;
      logic [LENGTH_W-1:0]                stored_length;
      logic [SLOT_W-1:0]                  slot;
   } rsp_data_type;

   // One descriptor row of the slot memory
   typedef struct packed {
      logic                written;
      logic                live;
      logic [FRAME_W-1:0]  frame;
      logic [PACKET_W-1:0] packet;
      logic [LENGTH_W-1:0] length;
      logic [STAMP_W-1:0]  stamp;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_OLD,
      ST_SCAN,
      ST_WRITE,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic read_ptr;
      logic latch_old;
      logic scan_issue;
      logic compare;
      logic write_slot;
      logic clear_step;
      logic load_rsp;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_lookup;
      logic scan_done;
      logic scan_last;
      logic last_cmp;
      logic hit;
   } dp_stat_type;

endpackage

`default_nettype wire

### rtl/core/retransmit_descriptor_table.sv
// Top level of the retransmit descriptor table
//
// Keeps one descriptor (frame number, packet number, length, send time) per
// slot of a ring of SLOTS slots; payload bytes live outside, addressed by slot.
// Input channel req_*: req_tuser is the command (store or look up and remove),
// req_tdata the key, length and current time. Result channel rsp_*: one item
// per input item, rsp_tuser the status, rsp_tdata slot, length and elapsed time.
// A store walks the whole slot memory through its single read port, one slot
// a cycle, comparing the key of every live row; a lookup stops at its first hit.
// A store first reads the slot at the push pointer, then scans, writes its row
// and loads the result; the next item can be taken in the same cycle that
// rsp_tvalid rises. A lookup that misses scans every slot.
// After reset a clearing pass marks every slot empty; req_tready stays low
// meanwhile. When the receiver stalls, the result waits in the output
// register; one more item is taken and worked off, then the block holds until
// the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module retransmit_descriptor_table
   import rdt_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // frame_number, packet_number, length, now
   input  wire logic [0:0]            req_tuser,   // cmd
   // Result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,   // slot, stored_length, elapsed
   output logic      [RSP_USER_W-1:0] rsp_tuser    // status
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   rdt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser[0]),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rdt_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_cmd   (req_tuser[0]),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

### rtl/core/rdt_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module rdt_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/rdt_ctrl.sv
// Controller state machine of the retransmit descriptor table
`timescale 1ns / 1ps
`default_nettype none

module rdt_ctrl
   import rdt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_cmd,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire dp_stat_type stat,
   output ctrl_cmd_type     cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // State and output valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Clear the slots after reset, then sequence each item: capture, scan the slots, write a store, hand off the result
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               if (req_cmd == CMD_STORE) begin
                  cmd.read_ptr = 1'b1;
                  state_in     = ST_OLD;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_OLD: begin
            cmd.latch_old  = 1'b1;
            cmd.scan_issue = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_issue = !stat.scan_done;
            cmd.compare    = 1'b1;
            if (stat.is_lookup && stat.hit) begin
               state_in = ST_FINISH;
            end else if (stat.last_cmp) begin
               state_in = stat.is_lookup ? ST_FINISH : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write_slot = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/core/rdt_datapath.sv
// Datapath: request registers, slot memory, key compare and result registers
`timescale 1ns / 1ps
`default_nettype none

module rdt_datapath
   import rdt_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_cmd,
   input  wire ctrl_cmd_type          cmd,
   output dp_stat_type                stat,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   output logic      [RSP_USER_W-1:0] rsp_tuser
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   req_data_type req;
   row_type      rd_row;
   row_type      wr_row;
   logic [ROW_W-1:0] rd_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;

   // Control registers
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic             scan_done_ff, scan_done_in;
   logic             cmp_valid_ff, cmp_valid_in;

   // Payload registers
   logic                cmd_ff, cmd_in;
   logic [FRAME_W-1:0]  frame_ff, frame_in;
   logic [PACKET_W-1:0] packet_ff, packet_in;
   logic [LENGTH_W-1:0] length_ff, length_in;
   logic [STAMP_W-1:0]  now_ff, now_in;
   logic [FRAME_W-1:0]  old_frame_ff, old_frame_in;
   logic [PACKET_W-1:0] old_packet_ff, old_packet_in;
   logic                old_valid_ff, old_valid_in;
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   status_type          res_status_ff, res_status_in;
   logic [IDX_W-1:0]    res_slot_ff, res_slot_in;
   logic [LENGTH_W-1:0] res_length_ff, res_length_in;
   logic [STAMP_W-1:0]  res_elapsed_ff, res_elapsed_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [LENGTH_W-1:0] rsp_length_ff, rsp_length_in;
   logic [STAMP_W-1:0]  rsp_elapsed_ff, rsp_elapsed_in;

   logic                   key_new;
   logic                   key_old;
   logic                   match_lookup;
   logic                   match_store;
   logic                   match;
   logic [IDX_W+SLOT_W-1:0] slot_wide;
   rsp_data_type           rsp_word;

   assign req    = req_data_type'(req_tdata);
   assign rd_row = row_type'(rd_data);

   // Compare the row read back against the search keys
   assign key_new      = (rd_row.frame == frame_ff) && (rd_row.packet == packet_ff);
   assign key_old      = old_valid_ff && (rd_row.frame == old_frame_ff)
                         && (rd_row.packet == old_packet_ff);
   assign match_lookup = cmp_valid_ff && rd_row.live && key_new;
   assign match_store  = cmp_valid_ff && rd_row.live && (key_new || key_old);
   assign match        = (cmd_ff == CMD_LOOKUP) ? match_lookup : match_store;

   // Read port: the slot at the push pointer, or the next slot of the scan
   assign rd_en   = cmd.read_ptr || cmd.scan_issue;
   assign rd_addr = cmd.read_ptr ? ptr_ff : scan_idx_ff;

   // Write port: clear a row, store a new descriptor, or drop a live mapping
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = scan_idx_ff;
      wr_row  = '0;
      if (cmd.clear_step) begin
         wr_en = 1'b1;
      end else if (cmd.write_slot) begin
         wr_en          = 1'b1;
         wr_addr        = ptr_ff;
         wr_row.written = 1'b1;
         wr_row.live    = 1'b1;
         wr_row.frame   = frame_ff;
         wr_row.packet  = packet_ff;
         wr_row.length  = length_ff;
         wr_row.stamp   = now_ff;
      end else if (cmd.compare && match) begin
         wr_en       = 1'b1;
         wr_addr     = cmp_idx_ff;
         wr_row      = rd_row;
         wr_row.live = 1'b0;
      end
   end

   rdt_ram #(
      .DATA_W (ROW_W),
      .DEPTH  (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_wide = {{SLOT_W{1'b0}}, res_slot_ff};

   // Next values of all registers
   always_comb begin
      ptr_in         = ptr_ff;
      scan_idx_in    = scan_idx_ff;
      scan_done_in   = scan_done_ff;
      cmp_valid_in   = cmd.scan_issue;
      cmp_idx_in     = scan_idx_ff;
      cmd_in         = cmd_ff;
      frame_in       = frame_ff;
      packet_in      = packet_ff;
      length_in      = length_ff;
      now_in         = now_ff;
      old_frame_in   = old_frame_ff;
      old_packet_in  = old_packet_ff;
      old_valid_in   = old_valid_ff;
      res_status_in  = res_status_ff;
      res_slot_in    = res_slot_ff;
      res_length_in  = res_length_ff;
      res_elapsed_in = res_elapsed_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_length_in  = rsp_length_ff;
      rsp_elapsed_in = rsp_elapsed_ff;

      // Take the item; saturate the length, preset the result to a miss
      if (cmd.capture) begin
         cmd_in         = req_cmd;
         frame_in       = req.frame;
         packet_in      = req.packet;
         length_in      = (req.length > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : req.length;
         now_in         = req.now;
         scan_idx_in    = '0;
         scan_done_in   = 1'b0;
         res_status_in  = STATUS_MISS;
         res_slot_in    = '0;
         res_length_in  = '0;
         res_elapsed_in = '0;
      end

      // Hold the key that the slot at the push pointer carried
      if (cmd.latch_old) begin
         old_frame_in  = rd_row.frame;
         old_packet_in = rd_row.packet;
         old_valid_in  = rd_row.written;
      end

      // Advance the scan or clear index with wrap
      if (cmd.scan_issue || cmd.clear_step) begin
         scan_idx_in = (scan_idx_ff == LAST_IDX) ? '0 : scan_idx_ff + 1'b1;
         if (scan_idx_ff == LAST_IDX) begin
            scan_done_in = 1'b1;
         end
      end

      // Record a lookup hit
      if (cmd.compare && (cmd_ff == CMD_LOOKUP) && match_lookup) begin
         res_status_in  = STATUS_HIT;
         res_slot_in    = cmp_idx_ff;
         res_length_in  = rd_row.length;
         res_elapsed_in = now_ff - rd_row.stamp;
      end

      // Store done: report the slot and advance the push pointer
      if (cmd.write_slot) begin
         res_status_in = STATUS_STORED;
         res_slot_in   = ptr_ff;
         ptr_in        = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
      end

      // Move the result into the output register
      if (cmd.load_rsp) begin
         rsp_status_in  = res_status_ff;
         rsp_slot_in    = slot_wide[SLOT_W-1:0];
         rsp_length_in  = res_length_ff;
         rsp_elapsed_in = res_elapsed_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         scan_idx_ff  <= '0;
         scan_done_ff <= 1'b0;
         cmp_valid_ff <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         scan_idx_ff  <= scan_idx_in;
         scan_done_ff <= scan_done_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      frame_ff       <= frame_in;
      packet_ff      <= packet_in;
      length_ff      <= length_in;
      now_ff         <= now_in;
      old_frame_ff   <= old_frame_in;
      old_packet_ff  <= old_packet_in;
      old_valid_ff   <= old_valid_in;
      cmp_idx_ff     <= cmp_idx_in;
      res_status_ff  <= res_status_in;
      res_slot_ff    <= res_slot_in;
      res_length_ff  <= res_length_in;
      res_elapsed_ff <= res_elapsed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_length_ff  <= rsp_length_in;
      rsp_elapsed_ff <= rsp_elapsed_in;
   end

   // Status toward the controller
   assign stat.is_lookup = (cmd_ff == CMD_LOOKUP);
   assign stat.scan_done = scan_done_ff;
   assign stat.scan_last = (scan_idx_ff == LAST_IDX);
   assign stat.last_cmp  = cmp_valid_ff && (cmp_idx_ff == LAST_IDX);
   assign stat.hit       = match_lookup;

   // Output word
   always_comb begin
      rsp_word               = '0;
      rsp_word.slot          = rsp_slot_ff;
      rsp_word.stored_length = rsp_length_ff;
      rsp_word.elapsed       = rsp_elapsed_ff;
   end

   assign rsp_tdata = rsp_word;
   assign rsp_tuser = rsp_status_ff;

endmodule

`default_nettype wire

### rtl/core/rdt_checker.sv
// Port checker of the retransmit descriptor table and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "retransmit_descriptor_table_defines.svh"

module rdt_checker
   import rdt_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [RSP_USER_W-1:0] rsp_tuser
);

   // Reset empties the output register
   `RDT_ASSERT_NEXT_RAW(a_reset_quiet, reset, !rsp_tvalid)

   // One item at a time: no acceptance right after an acceptance
   `RDT_ASSERT_NEXT(a_one_item, req_tvalid && req_tready, !req_tready)

   // A stalled result holds
   `RDT_ASSERT_NEXT(a_stall_hold, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // A store reports only its slot: length and elapsed are zero
   `RDT_ASSERT_NOW(a_store_fields, rsp_tvalid && (rsp_tuser == STATUS_STORED), rsp_tdata[49:6] == '0)

   // A miss reports all fields zero
   `RDT_ASSERT_NOW(a_miss_fields, rsp_tvalid && (rsp_tuser == STATUS_MISS), rsp_tdata[49:0] == '0)

endmodule

bind retransmit_descriptor_table rdt_checker u_rdt_checker (.*);

`default_nettype wire
